// ===== hdl/variable_record_ring_queue_core_assert.svh =====
// assertion macros shared by the ring queue modules
`ifndef VARIABLE_RECORD_RING_QUEUE_CORE_ASSERT_SVH
`define VARIABLE_RECORD_RING_QUEUE_CORE_ASSERT_SVH

// same-cycle implication, off while in reset
`define VRRQ_ASSERT_IMPL(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("ring queue assertion failed");

// next-cycle implication, off while in reset
`define VRRQ_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("ring queue assertion failed");

`endif

// ===== hdl/vrrq_pkg.sv =====
`default_nettype none

package vrrq_pkg;

  localparam int BUF_BYTES_DEF = 4096;
  localparam int HDR_BYTES     = 4;

  // function codes of an input word
  localparam logic [1:0] FUNC_PUSH  = 2'd0;
  localparam logic [1:0] FUNC_POP   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_ROOM    = 3'd1;
  localparam logic [2:0] ST_EMPTY      = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE  = 3'd3;
  localparam logic [2:0] ST_OUT_OF_SEQ = 3'd4;

  // datapath operations
  localparam logic [3:0] OP_NOP       = 4'd0;
  localparam logic [3:0] OP_OOS       = 4'd1;
  localparam logic [3:0] OP_CLEAR     = 4'd2;
  localparam logic [3:0] OP_ADMIT     = 4'd3;
  localparam logic [3:0] OP_REJECT    = 4'd4;
  localparam logic [3:0] OP_SWALLOW   = 4'd5;
  localparam logic [3:0] OP_PUSH_BYTE = 4'd6;
  localparam logic [3:0] OP_EMPTY     = 4'd7;
  localparam logic [3:0] OP_WRAP      = 4'd8;
  localparam logic [3:0] OP_POP_HEAD  = 4'd9;
  localparam logic [3:0] OP_POP_BYTE  = 4'd10;
  localparam logic [3:0] OP_PUSH_DONE = 4'd11;

  // header byte steps 0..3, payload byte 0 at the last step
  localparam logic [2:0] STEP_LAST = 3'd4;

  typedef struct packed {
    logic       load;
    logic       fin;
    logic [3:0] op;
    logic       hdr_wr;
    logic       hdr_rd;
    logic [2:0] step;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       first;
    logic       push_open;
    logic       push_rej;
    logic       pop_open;
    logic       empty;
    logic       admit;
  } stat_t;

endpackage

`default_nettype wire

// ===== hdl/variable_record_ring_queue_core.sv =====
// continuing push or pop, clear, refused push, empty pop, out of sequence: answered from the evaluation state
// first push of an admitted record: header bytes go through the byte-wide store port
// first pop of a held record: header read back a byte a cycle, registered read data
// result is registered, done is high for one cycle and cannot be held off by the receiver
// busy drops with done, so the next word is taken at the edge that ends the result cycle
// synchronous reset empties the queue; store contents stay undefined until written
`default_nettype none

module variable_record_ring_queue_core #(
  parameter int BUF_BYTES = vrrq_pkg::BUF_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // command side: a word is taken when start is high and busy is low
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       func,
  input  logic                             first,
  input  logic [15:0]                      identifier,
  input  logic [15:0]                      payload_length,
  input  logic [7:0]                       data_byte,
  input  logic [15:0]                      reader_capacity,
  // result side: one result word per command word, strobed by done
  output logic                             done,
  output logic [2:0]                       status,
  output logic [15:0]                      tag_out,
  output logic [15:0]                      length_out,
  output logic [7:0]                       byte_out,
  output logic                             byte_valid,
  output logic                             last,
  output logic [$clog2(BUF_BYTES+1)-1:0]   bytes_used,
  output logic [$clog2(BUF_BYTES/4+1)-1:0] records_held
);
  import vrrq_pkg::*;

  // controller to datapath commands and datapath flags back
  cmd_t  cmd;
  stat_t stat;

  // sequencer: decodes the word, runs the header write or read sweep
  vrrq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // byte store, ring pointers, admission check and result register
  vrrq_dpath #(
    .BUF_BYTES (BUF_BYTES)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .func            (func),
    .first           (first),
    .identifier      (identifier),
    .payload_length  (payload_length),
    .data_byte       (data_byte),
    .reader_capacity (reader_capacity),
    .done            (done),
    .status          (status),
    .tag_out         (tag_out),
    .length_out      (length_out),
    .byte_out        (byte_out),
    .byte_valid      (byte_valid),
    .last            (last),
    .bytes_used      (bytes_used),
    .records_held    (records_held)
  );

endmodule

`default_nettype wire

// ===== hdl/vrrq_ctrl.sv =====
`default_nettype none
`include "variable_record_ring_queue_core_assert.svh"

module vrrq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  vrrq_pkg::stat_t stat,
  output vrrq_pkg::cmd_t  cmd,
  output logic           busy
);
  import vrrq_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EVAL     = 3'd1;
  localparam logic [2:0] S_HDR_WR   = 3'd2;
  localparam logic [2:0] S_HDR_RD   = 3'd3;
  localparam logic [2:0] S_POP_HEAD = 3'd4;

  logic [2:0] state, state_next;
  logic [2:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    cmd.step   = step;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          step_next  = '0;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.fin    = 1'b1;
        state_next = S_IDLE;
        unique case (stat.func)
          FUNC_PUSH: begin
            if (stat.first) begin
              if (stat.push_open) begin
                cmd.op = OP_OOS;
              end else if (stat.admit) begin
                cmd.op     = OP_ADMIT;
                cmd.fin    = 1'b0;
                state_next = S_HDR_WR;
              end else begin
                cmd.op = OP_REJECT;
              end
            end else if (!stat.push_open) begin
              cmd.op = OP_OOS;
            end else if (stat.push_rej) begin
              cmd.op = OP_SWALLOW;
            end else begin
              cmd.op = OP_PUSH_BYTE;
            end
          end
          FUNC_POP: begin
            if (stat.first) begin
              if (stat.pop_open) begin
                cmd.op = OP_OOS;
              end else if (stat.empty) begin
                cmd.op = OP_EMPTY;
              end else begin
                cmd.op     = OP_WRAP;
                cmd.fin    = 1'b0;
                state_next = S_HDR_RD;
              end
            end else if (!stat.pop_open) begin
              cmd.op = OP_OOS;
            end else begin
              cmd.op = OP_POP_BYTE;
            end
          end
          FUNC_CLEAR: cmd.op = OP_CLEAR;
          default:    cmd.op = OP_OOS;
        endcase
      end
      S_HDR_WR: begin
        cmd.hdr_wr = 1'b1;
        if (step == STEP_LAST) begin
          cmd.fin    = 1'b1;
          cmd.op     = OP_PUSH_DONE;
          state_next = S_IDLE;
        end else begin
          step_next = step + 3'd1;
        end
      end
      S_HDR_RD: begin
        cmd.hdr_rd = 1'b1;
        if (step == STEP_LAST) begin
          state_next = S_POP_HEAD;
        end else begin
          step_next = step + 3'd1;
        end
      end
      S_POP_HEAD: begin
        cmd.fin    = 1'b1;
        cmd.op     = OP_POP_HEAD;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  `VRRQ_ASSERT_IMPL(a_step_range, clk, rst, state == S_HDR_WR || state == S_HDR_RD, step <= STEP_LAST)
  `VRRQ_ASSERT_IMPL(a_idle_on_fin, clk, rst, state != S_IDLE && state_next == S_IDLE, cmd.fin)
  `VRRQ_ASSERT_NEXT(a_load_to_eval, clk, rst, cmd.load, state == S_EVAL)

endmodule

`default_nettype wire

// ===== hdl/vrrq_dpath.sv =====
`default_nettype none
`include "variable_record_ring_queue_core_assert.svh"

module vrrq_dpath #(
  parameter int BUF_BYTES = vrrq_pkg::BUF_BYTES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  vrrq_pkg::cmd_t                        cmd,
  output vrrq_pkg::stat_t                       stat,
  input  logic [1:0]                            func,
  input  logic                                  first,
  input  logic [15:0]                           identifier,
  input  logic [15:0]                           payload_length,
  input  logic [7:0]                            data_byte,
  input  logic [15:0]                           reader_capacity,
  output logic                                  done,
  output logic [2:0]                            status,
  output logic [15:0]                           tag_out,
  output logic [15:0]                           length_out,
  output logic [7:0]                            byte_out,
  output logic                                  byte_valid,
  output logic                                  last,
  output logic [$clog2(BUF_BYTES+1)-1:0]        bytes_used,
  output logic [$clog2(BUF_BYTES/4+1)-1:0]      records_held
);
  import vrrq_pkg::*;

  localparam int POS_W  = $clog2(BUF_BYTES + 1);
  localparam int CNT_W  = $clog2(BUF_BYTES / 4 + 1);
  localparam int ADDR_W = $clog2(BUF_BYTES);
  localparam int SUM_W  = ((POS_W > 17) ? POS_W : 17) + 1;

  // latched input word
  logic [1:0]  in_func;
  logic        in_first;
  logic [15:0] in_ident, in_len, in_cap;
  logic [7:0]  in_dbyte;

  // queue state
  logic [POS_W-1:0] insert_pos, terminal_pos, read_pos, used_bytes, wr_base;
  logic [CNT_W-1:0] record_count;
  logic [15:0]      push_remaining, pop_remaining, pop_tag, pop_length;
  logic             push_rejected;

  logic [POS_W-1:0] ins_next, term_next, rp_next, used_next, base_next;
  logic [CNT_W-1:0] cnt_next;
  logic [15:0]      prem_next, qrem_next, ptag_next, plen_next;
  logic             prej_next;

  logic [7:0] mem [BUF_BYTES];
  logic [7:0] rdata;

  // admission
  logic [SUM_W-1:0] need_s, ins_s, term_s, rd_s, used_s, ins_eff_s, ins_end;
  logic             fits, wrap, wrap_ok, behind;
  logic [POS_W-1:0] ins_eff;

  // record consumption
  logic [SUM_W-1:0] rec_sz;
  logic [POS_W-1:0] rp_cons, used_cons;
  logic [CNT_W-1:0] cnt_cons;
  logic             consume;

  // memory port
  logic             mem_we;
  logic [SUM_W-1:0] wa_full, ra_full;
  logic [7:0]       mem_wdata;

  // result word
  logic [2:0]  o_status;
  logic [15:0] o_tag, o_len;
  logic [7:0]  o_byte;
  logic        o_bvalid, o_last;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_func  <= func;
      in_first <= first;
      in_ident <= identifier;
      in_len   <= payload_length;
      in_dbyte <= data_byte;
      in_cap   <= reader_capacity;
    end
  end

  assign need_s  = SUM_W'(in_len) + SUM_W'(HDR_BYTES);
  assign ins_s   = SUM_W'(insert_pos);
  assign term_s  = SUM_W'(terminal_pos);
  assign rd_s    = SUM_W'(read_pos);
  assign used_s  = SUM_W'(used_bytes);

  assign fits      = (used_s + need_s) <= SUM_W'(BUF_BYTES);
  assign wrap      = (insert_pos == terminal_pos) && ((ins_s + need_s) > SUM_W'(BUF_BYTES));
  assign wrap_ok   = rd_s >= need_s;
  assign ins_eff   = wrap ? '0 : insert_pos;
  assign ins_eff_s = SUM_W'(ins_eff);
  assign ins_end   = ins_eff_s + need_s;
  assign behind    = (ins_eff < terminal_pos) && (ins_end > rd_s);

  assign stat.func      = in_func;
  assign stat.first     = in_first;
  assign stat.push_open = (push_remaining != '0);
  assign stat.push_rej  = push_rejected;
  assign stat.pop_open  = (pop_remaining != '0);
  assign stat.empty     = (record_count == '0);
  assign stat.admit     = fits && !(wrap && !wrap_ok) && !behind;

  assign rec_sz    = SUM_W'(pop_length) + SUM_W'(HDR_BYTES);
  assign rp_cons   = POS_W'(rd_s + rec_sz);
  assign used_cons = (used_s >= rec_sz) ? POS_W'(used_s - rec_sz) : '0;
  assign cnt_cons  = (record_count != '0) ? record_count - CNT_W'(1) : record_count;

  // memory addressing: header sweep, or the open record's next byte
  assign wa_full = cmd.hdr_wr ? SUM_W'(wr_base) + SUM_W'(cmd.step)
                              : ins_s - SUM_W'(push_remaining);
  assign ra_full = cmd.hdr_rd ? rd_s + SUM_W'(cmd.step)
                              : rd_s + SUM_W'(HDR_BYTES) + SUM_W'(pop_length)
                                - SUM_W'(pop_remaining);
  assign mem_we  = (cmd.hdr_wr && ((cmd.step != STEP_LAST) || (in_len != '0)))
                   || (cmd.op == OP_PUSH_BYTE);

  always_comb begin
    case (cmd.step)
      3'd0:    mem_wdata = in_len[7:0];
      3'd1:    mem_wdata = in_len[15:8];
      3'd2:    mem_wdata = in_ident[7:0];
      3'd3:    mem_wdata = in_ident[15:8];
      default: mem_wdata = in_dbyte;
    endcase
    if (!cmd.hdr_wr) mem_wdata = in_dbyte;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wa_full[ADDR_W-1:0]] <= mem_wdata;
    rdata <= mem[ra_full[ADDR_W-1:0]];
  end

  always_comb begin
    ins_next  = insert_pos;
    term_next = terminal_pos;
    rp_next   = read_pos;
    used_next = used_bytes;
    cnt_next  = record_count;
    prem_next = push_remaining;
    prej_next = push_rejected;
    qrem_next = pop_remaining;
    ptag_next = pop_tag;
    plen_next = pop_length;
    base_next = wr_base;
    consume   = 1'b0;
    o_status  = ST_OK;
    o_tag     = '0;
    o_len     = '0;
    o_byte    = '0;
    o_bvalid  = 1'b0;
    o_last    = 1'b0;
    unique case (cmd.op)
      OP_OOS:   o_status = ST_OUT_OF_SEQ;
      OP_EMPTY: o_status = ST_EMPTY;
      OP_CLEAR: begin
        ins_next  = '0;
        term_next = '0;
        rp_next   = '0;
        used_next = '0;
        cnt_next  = '0;
        prem_next = '0;
        prej_next = 1'b0;
        qrem_next = '0;
        ptag_next = '0;
        plen_next = '0;
      end
      OP_ADMIT: begin
        base_next = ins_eff;
        ins_next  = POS_W'(ins_end);
        used_next = POS_W'(used_s + need_s);
        if (ins_end > term_s) term_next = POS_W'(ins_end);
        if (in_len != '0) prem_next = in_len - 16'd1;
        if (in_len <= 16'd1) cnt_next = record_count + CNT_W'(1);
      end
      OP_REJECT: begin
        o_status = ST_NO_ROOM;
        if (in_len != '0) begin
          prem_next = in_len - 16'd1;
          prej_next = (in_len != 16'd1);
        end
      end
      OP_SWALLOW: begin
        o_status  = ST_NO_ROOM;
        prem_next = push_remaining - 16'd1;
        if (push_remaining == 16'd1) prej_next = 1'b0;
      end
      OP_PUSH_BYTE: begin
        prem_next = push_remaining - 16'd1;
        if (push_remaining == 16'd1) cnt_next = record_count + CNT_W'(1);
      end
      OP_WRAP: begin
        if (read_pos == terminal_pos) begin
          rp_next   = '0;
          term_next = insert_pos;
        end
      end
      OP_POP_HEAD: begin
        o_tag = pop_tag;
        if (pop_length == '0) begin
          o_last  = 1'b1;
          consume = 1'b1;
        end else if (in_cap < pop_length) begin
          o_status = ST_TOO_LARGE;
          o_last   = 1'b1;
          consume  = 1'b1;
        end else begin
          o_len     = pop_length;
          o_byte    = rdata;
          o_bvalid  = 1'b1;
          qrem_next = pop_length - 16'd1;
          if (pop_length == 16'd1) begin
            o_last  = 1'b1;
            consume = 1'b1;
          end
        end
      end
      OP_POP_BYTE: begin
        o_tag     = pop_tag;
        o_len     = pop_length;
        o_byte    = rdata;
        o_bvalid  = 1'b1;
        qrem_next = pop_remaining - 16'd1;
        if (pop_remaining == 16'd1) begin
          o_last  = 1'b1;
          consume = 1'b1;
        end
      end
      default: ;
    endcase
    if (consume) begin
      rp_next   = rp_cons;
      used_next = used_cons;
      cnt_next  = cnt_cons;
    end
    if (cmd.hdr_rd) begin
      case (cmd.step)
        3'd1:    plen_next[7:0]  = rdata;
        3'd2:    plen_next[15:8] = rdata;
        3'd3:    ptag_next[7:0]  = rdata;
        3'd4:    ptag_next[15:8] = rdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      insert_pos     <= '0;
      terminal_pos   <= '0;
      read_pos       <= '0;
      used_bytes     <= '0;
      record_count   <= '0;
      push_remaining <= '0;
      push_rejected  <= 1'b0;
      pop_remaining  <= '0;
      pop_tag        <= '0;
      pop_length     <= '0;
      wr_base        <= '0;
      done           <= 1'b0;
    end else begin
      insert_pos     <= ins_next;
      terminal_pos   <= term_next;
      read_pos       <= rp_next;
      used_bytes     <= used_next;
      record_count   <= cnt_next;
      push_remaining <= prem_next;
      push_rejected  <= prej_next;
      pop_remaining  <= qrem_next;
      pop_tag        <= ptag_next;
      pop_length     <= plen_next;
      wr_base        <= base_next;
      done           <= cmd.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      status       <= o_status;
      tag_out      <= o_tag;
      length_out   <= o_len;
      byte_out     <= o_byte;
      byte_valid   <= o_bvalid;
      last         <= o_last;
      bytes_used   <= used_next;
      records_held <= cnt_next;
    end
  end

  `VRRQ_ASSERT_IMPL(a_used_max, clk, rst, 1'b1, SUM_W'(used_bytes) <= SUM_W'(BUF_BYTES))
  `VRRQ_ASSERT_IMPL(a_rej_open, clk, rst, push_rejected, push_remaining != '0)
  `VRRQ_ASSERT_IMPL(a_push_open, clk, rst, cmd.op == OP_PUSH_BYTE || cmd.op == OP_SWALLOW, push_remaining != '0)

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import vrrq_pkg::*;

  localparam int RING_BYTES = BUF_BYTES_DEF;
  localparam logic [1:0] FUNC_UNDEF = 2'd3;
  localparam int DIR_ROWS = 26;
  localparam int WORDS_PER_PHASE = 420;
  // sender gap per phase; the result side has no stall, so the third phase runs flat out
  localparam int PHASE_GAP [4] = '{0, 57, 0, 15};

  typedef struct packed {
    logic [1:0]  func;
    logic        first;
    logic [15:0] ident;
    logic [15:0] len;
    logic [7:0]  dbyte;
    logic [15:0] cap;
  } cmd_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] tag;
    logic [15:0] length;
    logic [7:0]  pop_byte;
    logic        valid;
    logic        last;
    logic [12:0] used;
    logic [10:0] held;
  } result_t;

  typedef struct packed {
    cmd_word_t w;
    logic      typed;
    result_t   r;
  } dir_row_t;

  localparam result_t NO_RES = '0;

  // opening sequence from reset; rows with typed set carry their own answer
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{'{FUNC_POP, 1'b1, 16'h0000, 16'h0000, 8'h00, 16'hFFFF}, 1'b1,
      '{ST_EMPTY, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, 13'd0, 11'd0}},
    '{'{FUNC_POP, 1'b0, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF}, 1'b1,
      '{ST_OUT_OF_SEQ, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, 13'd0, 11'd0}},
    '{'{FUNC_PUSH, 1'b0, 16'hFFFF, 16'hFFFF, 8'hFF, 16'h0000}, 1'b1,
      '{ST_OUT_OF_SEQ, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, 13'd0, 11'd0}},
    '{'{FUNC_UNDEF, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF}, 1'b1,
      '{ST_OUT_OF_SEQ, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, 13'd0, 11'd0}},
    '{'{FUNC_PUSH, 1'b1, 16'hFFFF, 16'h0000, 8'h00, 16'h0000}, 1'b1,
      '{ST_OK, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, 13'd4, 11'd1}},
    '{'{FUNC_PUSH, 1'b1, 16'h0000, 16'h0001, 8'hFF, 16'h0000}, 1'b1,
      '{ST_OK, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, 13'd9, 11'd2}},
    '{'{FUNC_PUSH, 1'b1, 16'hA5C3, 16'h0003, 8'h00, 16'h0000}, 1'b0, NO_RES},
    '{'{FUNC_PUSH, 1'b1, 16'h3C5A, 16'hFFFF, 8'hAA, 16'h0000}, 1'b1,
      '{ST_OUT_OF_SEQ, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, 13'd16, 11'd2}},
    '{'{FUNC_PUSH, 1'b0, 16'h0000, 16'h0000, 8'h81, 16'h0000}, 1'b0, NO_RES},
    '{'{FUNC_PUSH, 1'b0, 16'h0000, 16'h0000, 8'h7E, 16'h0000}, 1'b0, NO_RES},
    '{'{FUNC_POP, 1'b1, 16'h0000, 16'h0000, 8'h00, 16'h0000}, 1'b1,
      '{ST_OK, 16'hFFFF, 16'h0000, 8'h00, 1'b0, 1'b1, 13'd12, 11'd2}},
    '{'{FUNC_POP, 1'b1, 16'h0000, 16'h0000, 8'h00, 16'h0000}, 1'b1,
      '{ST_TOO_LARGE, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b1, 13'd7, 11'd1}},
    '{'{FUNC_POP, 1'b1, 16'h0000, 16'h0000, 8'h00, 16'h0003}, 1'b0, NO_RES},
    '{'{FUNC_POP, 1'b1, 16'h0000, 16'h0000, 8'h00, 16'hFFFF}, 1'b1,
      '{ST_OUT_OF_SEQ, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, 13'd7, 11'd1}},
    '{'{FUNC_POP, 1'b0, 16'h0000, 16'h0000, 8'h00, 16'h0000}, 1'b0, NO_RES},
    '{'{FUNC_POP, 1'b0, 16'h0000, 16'h0000, 8'h00, 16'h0000}, 1'b0, NO_RES},
    '{'{FUNC_PUSH, 1'b1, 16'h5A5A, 16'hFFFF, 8'hC3, 16'h0000}, 1'b1,
      '{ST_NO_ROOM, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, 13'd0, 11'd0}},
    '{'{FUNC_PUSH, 1'b0, 16'h0000, 16'h0000, 8'h3C, 16'h0000}, 1'b1,
      '{ST_NO_ROOM, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, 13'd0, 11'd0}},
    '{'{FUNC_POP, 1'b1, 16'h0000, 16'h0000, 8'h00, 16'hFFFF}, 1'b1,
      '{ST_EMPTY, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, 13'd0, 11'd0}},
    '{'{FUNC_CLEAR, 1'b0, 16'h0000, 16'h0000, 8'h00, 16'h0000}, 1'b1,
      '{ST_OK, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, 13'd0, 11'd0}},
    '{'{FUNC_PUSH, 1'b0, 16'h0000, 16'h0000, 8'h00, 16'h0000}, 1'b1,
      '{ST_OUT_OF_SEQ, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, 13'd0, 11'd0}},
    '{'{FUNC_PUSH, 1'b1, 16'h1234, 16'd4093, 8'h11, 16'h0000}, 1'b1,
      '{ST_NO_ROOM, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, 13'd0, 11'd0}},
    '{'{FUNC_CLEAR, 1'b1, 16'h0000, 16'h0000, 8'h00, 16'h0000}, 1'b1,
      '{ST_OK, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, 13'd0, 11'd0}},
    '{'{FUNC_PUSH, 1'b1, 16'h8001, 16'h0002, 8'h55, 16'h0000}, 1'b0, NO_RES},
    '{'{FUNC_CLEAR, 1'b0, 16'h0000, 16'h0000, 8'h00, 16'h0000}, 1'b1,
      '{ST_OK, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, 13'd0, 11'd0}},
    '{'{FUNC_POP, 1'b0, 16'h0000, 16'h0000, 8'h00, 16'h0000}, 1'b1,
      '{ST_OUT_OF_SEQ, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, 13'd0, 11'd0}}
  };

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  func;
  logic        first;
  logic [15:0] identifier;
  logic [15:0] payload_length;
  logic [7:0]  data_byte;
  logic [15:0] reader_capacity;
  logic        done;
  logic [2:0]  status;
  logic [15:0] tag_out;
  logic [15:0] length_out;
  logic [7:0]  byte_out;
  logic        byte_valid;
  logic        last;
  logic [12:0] bytes_used;
  logic [10:0] records_held;

  variable_record_ring_queue_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .func(func), .first(first), .identifier(identifier),
    .payload_length(payload_length), .data_byte(data_byte),
    .reader_capacity(reader_capacity),
    .done(done), .status(status), .tag_out(tag_out), .length_out(length_out),
    .byte_out(byte_out), .byte_valid(byte_valid), .last(last),
    .bytes_used(bytes_used), .records_held(records_held)
  );

  // shadow copy of the ring queue
  logic [7:0]  ring_mem [RING_BYTES];
  int unsigned wr_at, end_mark, rd_at, fill, rec_cnt;
  int unsigned push_left, pop_left, pop_tag_q, pop_len_q;
  logic        push_rej;

  result_t outcomes_due [$];
  int      mismatches = 0;
  int      gap_pct = 0;

  function automatic void ring_put(input int unsigned p, input logic [7:0] v);
    if (p < RING_BYTES) ring_mem[p] = v;
  endfunction

  function automatic logic [7:0] ring_get(input int unsigned p);
    return (p < RING_BYTES) ? ring_mem[p] : 8'h00;
  endfunction

  function automatic void ring_empty();
    wr_at = 0; end_mark = 0; rd_at = 0; fill = 0; rec_cnt = 0;
    push_left = 0; push_rej = 1'b0;
    pop_left = 0; pop_tag_q = 0; pop_len_q = 0;
  endfunction

  // head record fully read or dropped
  function automatic void retire_head();
    int unsigned sz;
    sz = HDR_BYTES + pop_len_q;
    rd_at += sz;
    fill = (fill >= sz) ? fill - sz : 0;
    if (rec_cnt > 0) rec_cnt--;
  endfunction

  // applies one command word to the shadow queue and returns its result word
  function automatic result_t ring_outcome(input cmd_word_t w);
    result_t     r;
    int unsigned need, at;
    logic        fits;
    r = '0;
    r.status = ST_OK;
    if (w.func == FUNC_PUSH) begin
      if (!w.first) begin
        if (push_left == 0) begin
          r.status = ST_OUT_OF_SEQ;
        end else begin
          push_left--;
          if (push_rej) begin
            if (push_left == 0) push_rej = 1'b0;
            r.status = ST_NO_ROOM;
          end else begin
            ring_put(wr_at - push_left - 1, w.dbyte);
            if (push_left == 0) rec_cnt++;
          end
        end
      end else if (push_left != 0) begin
        r.status = ST_OUT_OF_SEQ;
      end else begin
        need = HDR_BYTES + w.len;
        at = wr_at;
        fits = 1'b1;
        if (fill + need > RING_BYTES) fits = 1'b0;
        // no room left at the top: restart at zero if the reader has moved far enough
        if (fits && at == end_mark && at + need > RING_BYTES) begin
          if (rd_at >= need) at = 0;
          else fits = 1'b0;
        end
        // wrapped writer must stay behind the reader
        if (fits && at < end_mark && at + need > rd_at) fits = 1'b0;
        if (fits) begin
          ring_put(at, w.len[7:0]);
          ring_put(at + 1, w.len[15:8]);
          ring_put(at + 2, w.ident[7:0]);
          ring_put(at + 3, w.ident[15:8]);
          wr_at = at + need;
          fill += need;
          if (wr_at > end_mark) end_mark = wr_at;
          if (w.len == 0) begin
            rec_cnt++;
          end else begin
            ring_put(at + HDR_BYTES, w.dbyte);
            push_left = w.len - 1;
            if (push_left == 0) rec_cnt++;
          end
        end else begin
          if (w.len > 0) begin
            push_left = w.len - 1;
            push_rej = (push_left != 0);
          end
          r.status = ST_NO_ROOM;
        end
      end
    end else if (w.func == FUNC_POP) begin
      if (!w.first) begin
        if (pop_left == 0) begin
          r.status = ST_OUT_OF_SEQ;
        end else begin
          r.tag = pop_tag_q[15:0];
          r.length = pop_len_q[15:0];
          r.pop_byte = ring_get(rd_at + HDR_BYTES + (pop_len_q - pop_left));
          r.valid = 1'b1;
          pop_left--;
          if (pop_left == 0) begin
            r.last = 1'b1;
            retire_head();
          end
        end
      end else if (pop_left != 0) begin
        r.status = ST_OUT_OF_SEQ;
      end else if (rec_cnt == 0) begin
        r.status = ST_EMPTY;
      end else begin
        // reader hit the end mark: follow the writer back to zero
        if (rd_at == end_mark) begin
          rd_at = 0;
          end_mark = wr_at;
        end
        pop_len_q = 32'({ring_get(rd_at + 1), ring_get(rd_at)});
        pop_tag_q = 32'({ring_get(rd_at + 3), ring_get(rd_at + 2)});
        r.tag = pop_tag_q[15:0];
        if (pop_len_q == 0) begin
          r.last = 1'b1;
          retire_head();
        end else if (w.cap < pop_len_q) begin
          // too big for the reader: dropped whole
          r.last = 1'b1;
          retire_head();
          r.status = ST_TOO_LARGE;
        end else begin
          r.length = pop_len_q[15:0];
          r.pop_byte = ring_get(rd_at + HDR_BYTES);
          r.valid = 1'b1;
          pop_left = pop_len_q - 1;
          if (pop_left == 0) begin
            r.last = 1'b1;
            retire_head();
          end
        end
      end
    end else if (w.func == FUNC_CLEAR) begin
      ring_empty();
    end else begin
      r.status = ST_OUT_OF_SEQ;
    end
    r.used = fill[12:0];
    r.held = rec_cnt[10:0];
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatches < 100) $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // sends one word, waits for it to be taken, then books its result
  task automatic issue(input cmd_word_t w, input logic typed, input result_t want,
                       output result_t due);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
    end
    start <= 1'b1;
    func <= w.func;
    first <= w.first;
    identifier <= w.ident;
    payload_length <= w.len;
    data_byte <= w.dbyte;
    reader_capacity <= w.cap;
    do @(posedge clk); while (busy);
    due = ring_outcome(w);
    if (typed) due = want;
    outcomes_due.push_back(due);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side: one word per done, compared with the oldest booked result
  always @(posedge clk) begin
    result_t e;
    if (!rst && done) begin
      if (outcomes_due.size() == 0) begin
        flag_mismatch("result word with none outstanding");
      end else begin
        e = outcomes_due.pop_front();
        if (status !== e.status)
          flag_mismatch($sformatf("status %0d, want %0d", status, e.status));
        if (tag_out !== e.tag)
          flag_mismatch($sformatf("tag_out %h, want %h", tag_out, e.tag));
        if (length_out !== e.length)
          flag_mismatch($sformatf("length_out %0d, want %0d", length_out, e.length));
        if (byte_out !== e.pop_byte)
          flag_mismatch($sformatf("byte_out %h, want %h", byte_out, e.pop_byte));
        if (byte_valid !== e.valid)
          flag_mismatch($sformatf("byte_valid %b, want %b", byte_valid, e.valid));
        if (last !== e.last)
          flag_mismatch($sformatf("last %b, want %b", last, e.last));
        if (bytes_used !== e.used)
          flag_mismatch($sformatf("bytes_used %0d, want %0d", bytes_used, e.used));
        if (records_held !== e.held)
          flag_mismatch($sformatf("records_held %0d, want %0d", records_held, e.held));
      end
    end
  end

  initial begin
    cmd_word_t w;
    result_t   e;
    int        roll;
    int        refusals;
    logic      filling;
    rst <= 1'b1;
    start <= 1'b0;
    func <= FUNC_PUSH;
    first <= 1'b0;
    identifier <= '0;
    payload_length <= '0;
    data_byte <= '0;
    reader_capacity <= '0;
    ring_empty();
    refusals = 0;
    filling = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) issue(DIR_TAB[i].w, DIR_TAB[i].typed, DIR_TAB[i].r, e);

    // well-formed records with random content, interleaved pushes and pops,
    // alternating between filling toward the wrap and draining, plus some noise
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = PHASE_GAP[ph];
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        w.ident = 16'($urandom_range(0, 65535));
        w.len = 16'($urandom_range(0, 65535));
        w.dbyte = 8'($urandom_range(0, 255));
        w.cap = 16'($urandom_range(0, 65535));
        w.first = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 99);
        if (push_rej && push_left > 40) begin
          // long refused record: abort rather than swallow it byte by byte
          w.func = FUNC_CLEAR;
        end else if (roll < 4) begin
          w.func = 2'($urandom_range(0, 3));
          if (w.func == FUNC_CLEAR && $urandom_range(0, 9) != 0) w.func = FUNC_UNDEF;
          if (w.func == FUNC_PUSH && w.first && $urandom_range(0, 3) != 0)
            w.len = 16'($urandom_range(0, 24));
        end else if (roll < (filling ? 92 : 20)) begin
          w.func = FUNC_PUSH;
          w.first = (push_left == 0);
          if (w.first) begin
            roll = $urandom_range(0, 99);
            if (roll < 75) w.len = '0;
            else if (roll < 95) w.len = 16'($urandom_range(1, 3));
            else w.len = 16'($urandom_range(4, 40));
          end
        end else begin
          w.func = FUNC_POP;
          w.first = (pop_left == 0);
          if (w.first && $urandom_range(0, 3) == 0) w.cap = 16'($urandom_range(0, 6));
        end
        issue(w, 1'b0, NO_RES, e);
        if (w.func == FUNC_PUSH && w.first && e.status == ST_NO_ROOM) refusals++;
        if (filling && (refusals >= 4 || fill > RING_BYTES - 200)) begin
          filling = 1'b0;
          refusals = 0;
        end else if (!filling && rec_cnt == 0) begin
          filling = 1'b1;
        end
      end
    end

    start <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
